### rtl/core/sib_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the snapshot interpolation buffer.
// No dependencies; imported by the controller, the datapath and the top level.
package sib_pkg;

	localparam int TIME_W   = 48;   // timestamp width, ns
	localparam int POS_W    = 32;   // Q16.16 position width
	localparam int DELAY_W  = 32;   // render delay width, ns
	localparam int MAG_W    = 33;   // magnitude of a position difference
	localparam int MIN_PAIR = 2;    // samples needed to interpolate

	localparam logic [DELAY_W-1:0] RESET_DELAY = 32'd200_000_000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH,
		ST_RCHK,
		ST_POP_CMP,
		ST_RD0,
		ST_LOAD0,
		ST_DIV,
		ST_APPLY,
		ST_DONE
	} sib_state_t;

	typedef struct packed {
		logic load_item;   // latch the accepted request
		logic push_write;  // store a sample, drop the oldest if full
		logic rd_slot1;    // read address: second sample (else oldest)
		logic pop;         // discard the oldest sample
		logic keep_pair;   // capture the second sample from read data
		logic setup_div;   // capture the oldest sample, prime the divider
		logic div_step;    // one quotient step
		logic apply;       // commit the interpolated position
		logic out_load;    // load the result register
	} sib_cmd_t;

	typedef struct packed {
		logic is_push;     // latched request is a push
		logic rt_ok;       // render time is not before zero
		logic has_pair;    // at least two samples held
		logic rd_le_rt;    // read timestamp not later than render time
		logic div_last;    // final quotient step
	} sib_sts_t;

endpackage

### rtl/core/sib_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sib_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/sib_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller: push, pop loop, interpolation and result hand-off.
// Depends on sib_pkg for the state type and the command/status structs.
module sib_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  sib_pkg::sib_sts_t  sts,
	output sib_pkg::sib_cmd_t  cmd
);

	import sib_pkg::*;

	sib_state_t state_q;
	sib_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PUSH;
				end
			end
			// first cycle after accept: write a push, pass a render tick on to the pair check
			ST_PUSH:    state_d = sts.is_push ? ST_DONE : ST_RCHK;
			ST_RCHK: begin
				state_d = (sts.rt_ok && sts.has_pair) ? ST_POP_CMP : ST_DONE;
			end
			ST_POP_CMP: state_d = sts.rd_le_rt ? ST_RCHK : ST_RD0;
			ST_RD0:     state_d = ST_LOAD0;
			ST_LOAD0:   state_d = sts.rd_le_rt ? ST_DIV : ST_DONE;
			ST_DIV:     state_d = sts.div_last ? ST_APPLY : ST_DIV;
			ST_APPLY:   state_d = ST_DONE;
			ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:    cmd.load_item = in_valid;
			ST_PUSH:    cmd.push_write = sts.is_push;
			ST_RCHK:    cmd.rd_slot1 = 1'b1;
			ST_POP_CMP: begin
				cmd.pop       = sts.rd_le_rt;
				cmd.keep_pair = !sts.rd_le_rt;
			end
			ST_RD0:     cmd.rd_slot1 = 1'b0;
			ST_LOAD0:   cmd.setup_div = sts.rd_le_rt;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_APPLY:   cmd.apply = 1'b1;
			ST_DONE:    cmd.out_load = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/sib_dp.sv
`timescale 1ns / 1ps
// Datapath: sample store, FIFO pointers, render time, bit-serial scaled divider
// and result register. Depends on sib_pkg and sib_ram.
module sib_dp #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sib_pkg::DELAY_W-1:0]        cfg_data,
	input  logic                               action,
	input  logic [sib_pkg::TIME_W-1:0]         time_now,
	input  logic signed [sib_pkg::POS_W-1:0]   sample_position,
	input  sib_pkg::sib_cmd_t                  cmd,
	output sib_pkg::sib_sts_t                  sts,
	output logic signed [sib_pkg::POS_W-1:0]   position_out,
	output logic                               interpolated,
	output logic                               dropped,
	output logic [$clog2(DEPTH+1)-1:0]         fill_level
);

	import sib_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH+1);
	localparam int ENT_W = TIME_W + POS_W;
	localparam int DIV_W = TIME_W + 2;
	localparam int STP_W = $clog2(MAG_W);

	// FIFO and configuration state
	logic [DELAY_W-1:0] delay_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [POS_W-1:0]   held_q;

	// latched request
	logic               action_q;
	logic [TIME_W-1:0]  time_q;
	logic [POS_W-1:0]   pos_q;
	logic [TIME_W-1:0]  rt_q;
	logic               rt_ok_q;

	// interpolation operands and divider
	logic [TIME_W-1:0]  t1_q;
	logic [POS_W-1:0]   x1_q;
	logic [POS_W-1:0]   x0_q;
	logic [TIME_W-1:0]  num_q;
	logic [TIME_W-1:0]  den_q;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic [TIME_W-1:0]  r_q;
	logic [MAG_W:0]     q_q;
	logic [STP_W-1:0]   step_q;
	logic               interp_flag_q;
	logic               drop_flag_q;

	// result register
	logic [POS_W-1:0]   position_out_q;
	logic               interpolated_q;
	logic               dropped_q;
	logic [CW-1:0]      fill_level_q;

	// store ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [ENT_W-1:0]   ram_rdata;
	logic [TIME_W-1:0]  rd_time;
	logic [POS_W-1:0]   rd_pos;

	logic               full;
	logic [CW:0]        head_ext;
	logic [AW-1:0]      slot1;
	logic [AW-1:0]      tail;
	logic [AW-1:0]      head_inc;
	logic [TIME_W:0]    rt_diff;
	logic [MAG_W-1:0]   diff;
	logic [MAG_W-1:0]   mag_abs;
	logic [DIV_W-1:0]   acc;
	logic [DIV_W-1:0]   den1;
	logic [DIV_W-1:0]   den2;
	logic [DIV_W-1:0]   r_next;
	logic [1:0]         digit;

	function automatic logic [AW-1:0] wrap_idx(input logic [CW:0] s);
		logic [CW:0] w;
		begin
			w = s - (CW+1)'(DEPTH);
			return (s >= (CW+1)'(DEPTH)) ? w[AW-1:0] : s[AW-1:0];
		end
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign head_ext = {{(CW+1-AW){1'b0}}, head_q};
	assign slot1    = wrap_idx(head_ext + (CW+1)'(1));
	assign tail     = wrap_idx(head_ext + {1'b0, count_q});
	assign head_inc = (head_q == AW'(DEPTH-1)) ? '0 : head_q + AW'(1);

	// a full store overwrites the oldest slot, which is the old head
	assign ram_we    = cmd.push_write;
	assign ram_waddr = full ? head_q : tail;
	assign ram_raddr = cmd.rd_slot1 ? slot1 : head_q;

	sib_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({time_q, pos_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_time = ram_rdata[ENT_W-1:POS_W];
	assign rd_pos  = ram_rdata[POS_W-1:0];

	assign rt_diff = {1'b0, time_now} - {{(TIME_W+1-DELAY_W){1'b0}}, delay_q};

	// signed difference of positions, one bit wider than a position
	assign diff    = {x1_q[POS_W-1], x1_q} - {rd_pos[POS_W-1], rd_pos};
	assign mag_abs = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

	// one quotient step: shift in the next magnitude bit's multiple of num,
	// then take out den up to twice
	assign acc  = {1'b0, r_q, 1'b0} + (mag_q[MAG_W-1] ? {2'b00, num_q} : '0);
	assign den1 = {2'b00, den_q};
	assign den2 = {1'b0, den_q, 1'b0};

	always_comb begin
		priority if (acc >= den2) begin
			r_next = acc - den2;
			digit  = 2'd2;
		end else if (acc >= den1) begin
			r_next = acc - den1;
			digit  = 2'd1;
		end else begin
			r_next = acc;
			digit  = 2'd0;
		end
	end

	assign sts.is_push  = !action_q;
	assign sts.rt_ok    = rt_ok_q;
	assign sts.has_pair = (count_q >= CW'(MIN_PAIR));
	assign sts.rd_le_rt = (rd_time <= rt_q);
	assign sts.div_last = (step_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= RESET_DELAY;
			head_q  <= '0;
			count_q <= '0;
			held_q  <= '0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_data;
			end
			if (cmd.push_write) begin
				if (full) begin
					head_q <= head_inc;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end else if (cmd.pop) begin
				head_q  <= head_inc;
				count_q <= count_q - CW'(1);
			end
			if (cmd.apply) begin
				held_q <= neg_q ? (x0_q - q_q[POS_W-1:0]) : (x0_q + q_q[POS_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q      <= action;
			time_q        <= time_now;
			pos_q         <= sample_position;
			rt_q          <= rt_diff[TIME_W-1:0];
			rt_ok_q       <= !rt_diff[TIME_W];
			interp_flag_q <= 1'b0;
			drop_flag_q   <= 1'b0;
		end
		if (cmd.push_write) begin
			drop_flag_q <= full;
		end
		if (cmd.keep_pair) begin
			t1_q <= rd_time;
			x1_q <= rd_pos;
		end
		if (cmd.setup_div) begin
			x0_q   <= rd_pos;
			num_q  <= rt_q - rd_time;
			den_q  <= t1_q - rd_time;
			mag_q  <= mag_abs;
			neg_q  <= diff[MAG_W-1];
			r_q    <= '0;
			q_q    <= '0;
			step_q <= STP_W'(MAG_W-1);
		end
		if (cmd.div_step) begin
			r_q    <= r_next[TIME_W-1:0];
			q_q    <= {q_q[MAG_W-1:0], 1'b0} + {{(MAG_W-1){1'b0}}, digit};
			mag_q  <= {mag_q[MAG_W-2:0], 1'b0};
			step_q <= step_q - STP_W'(1);
		end
		if (cmd.apply) begin
			interp_flag_q <= 1'b1;
		end
		if (cmd.out_load) begin
			position_out_q <= held_q;
			interpolated_q <= interp_flag_q;
			dropped_q      <= drop_flag_q;
			fill_level_q   <= count_q;
		end
	end

	assign position_out = position_out_q;
	assign interpolated = interpolated_q;
	assign dropped      = dropped_q;
	assign fill_level   = fill_level_q;

endmodule

### rtl/core/snapshot_interpolation_buffer_top.sv
`timescale 1ns / 1ps
// Snapshot interpolation buffer, top level: controller plus datapath.
// Depends on sib_pkg, sib_ctrl, sib_dp (and through it sib_ram).
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ---------------------------------------
// in       in         in_valid / in_stall  action, time_now, sample_position
// out      out        out_valid/out_stall  position_out, interpolated, dropped,
//                                          fill_level
// cfg      in         cfg_valid/cfg_ready  render_delay
//
// A push writes its sample, then loads its result. A render tick loads its result when
// the render time is before zero or fewer than two samples remain, when the oldest sample
// is later than the render time, or after it interpolates through the bit-serial scaled
// divider, one quotient bit per cycle; each popped sample sends it back through the pair
// check. One request is in flight at a time; the next is accepted at the edge after a
// result load, even while that result waits behind out_stall.
// Reset clears the FIFO pointers and the held position and loads the
// render delay with 200 ms; the sample store needs no clearing.
module snapshot_interpolation_buffer_top #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic [sib_pkg::TIME_W-1:0]         time_now,
	input  logic signed [sib_pkg::POS_W-1:0]   sample_position,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [sib_pkg::POS_W-1:0]   position_out,
	output logic                               interpolated,
	output logic                               dropped,
	output logic [$clog2(DEPTH+1)-1:0]         fill_level,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sib_pkg::DELAY_W-1:0]        render_delay
);

	import sib_pkg::*;

	sib_cmd_t cmd;
	sib_sts_t sts;

	// the delay register takes a write in any cycle
	assign cfg_ready = 1'b1;

	sib_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sib_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (render_delay),
		.action          (action),
		.time_now        (time_now),
		.sample_position (sample_position),
		.cmd             (cmd),
		.sts             (sts),
		.position_out    (position_out),
		.interpolated    (interpolated),
		.dropped         (dropped),
		.fill_level      (fill_level)
	);

	// only one request in flight
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while another is in flight");

	// a result is either a push or a render tick, never both kinds of flag
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(interpolated && dropped))
		else $error("result flags both interpolated and dropped");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_level <= ($clog2(DEPTH+1))'(DEPTH)))
		else $error("fill level above store depth");

	// the final quotient step is always followed by the commit
	a_div_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && sts.div_last) |=> cmd.apply)
		else $error("divider finished without commit");

	// loading a result frees the input side on the next cycle
	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (!in_stall && out_valid))
		else $error("result load did not return to idle");

endmodule
